// ===== rtl/assert_macros.svh =====
// Assertion helpers. The including module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising clock edge out of reset
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// when cond holds, conseq must hold in the next cycle
`define CHK_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/rbsa_pkg.sv =====
`default_nettype none

package rbsa_pkg;

	localparam int CNT_W = 17;
	localparam int OFS_W = 16;
	localparam int REQ_W = 2;

	localparam logic [REQ_W-1:0] REQ_CHECK = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [CNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [OFS_W-1:0] offset;
		logic [CNT_W-1:0] freed_bytes;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/rbsa_if.sv =====
`default_nettype none

interface rbsa_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbsa_core.sv =====
`default_nettype none
`include "assert_macros.svh"

// Position/total state and the combinational decision for one request.
module rbsa_core #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rbsa_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                       adv,
	input  wire rbsa_pkg::req_t             req,
	output rbsa_pkg::res_t                  res
);

	localparam int PW = ADDR_BITS + 1;
	// common compare width: holds positions, sizes and a sum of three counts
	localparam int WW = ((PW > rbsa_pkg::CNT_W) ? PW : rbsa_pkg::CNT_W) + 2;
	localparam logic [WW-1:0] OFS_MASK = (WW'(1) << ADDR_BITS) - WW'(1);

	logic [rbsa_pkg::CNT_W-1:0] size_q;
	logic [PW-1:0]              next_q;
	logic [PW-1:0]              free_q;
	logic [rbsa_pkg::CNT_W-1:0] tot_q;

	logic [PW-1:0]              next_n;
	logic [PW-1:0]              free_n;
	logic [rbsa_pkg::CNT_W-1:0] tot_n;

	logic [WW-1:0] np, fp, bs, amt, tot;
	logic [WW-1:0] tail_np, tail_fp;
	logic          full, fit, wrap;
	logic [WW-1:0] where;

	function automatic logic [WW-1:0] tail(input logic [WW-1:0] pos,
			input logic [WW-1:0] size);
		return (size > pos) ? (size - pos) : '0;
	endfunction

	function automatic logic [rbsa_pkg::CNT_W-1:0] sat(input logic [WW-1:0] v);
		return (v > WW'(rbsa_pkg::CNT_MAX)) ? rbsa_pkg::CNT_MAX : rbsa_pkg::CNT_W'(v);
	endfunction

	assign np  = WW'(next_q);
	assign fp  = WW'(free_q);
	assign bs  = WW'(size_q);
	assign amt = WW'(req.amount);
	assign tot = WW'(tot_q);
	assign tail_np = tail(np, bs);
	assign tail_fp = tail(fp, bs);

	// placement of a block of amt bytes
	always_comb begin
		fit   = 1'b0;
		wrap  = 1'b0;
		where = '0;
		full  = (np == fp) && (tot != '0);
		if (full || amt > bs) begin
			fit = 1'b0;
		end else if (np >= fp) begin
			if (tail_np >= amt) begin
				fit   = 1'b1;
				where = np;
			end else if (fp >= amt) begin
				fit  = 1'b1;
				wrap = 1'b1;
			end
		end else if (fp - np >= amt) begin
			fit   = 1'b1;
			where = np;
		end
	end

	always_comb begin
		logic [WW-1:0] ofs;
		logic [WW-1:0] rel;
		logic [WW-1:0] e;
		logic          linear;
		ofs    = '0;
		rel    = tail_fp + amt;
		e      = fp + amt;
		linear = (fp < np) || ((fp == np) && (tot == '0));
		next_n = next_q;
		free_n = free_q;
		tot_n  = tot_q;
		res    = '0;
		unique case (req.req_type)
			rbsa_pkg::REQ_CHECK, rbsa_pkg::REQ_ALLOC: begin
				if (fit) begin
					res.ok = 1'b1;
					if (req.req_type == rbsa_pkg::REQ_ALLOC) begin
						if (wrap) begin
							tot_n  = sat(tot + tail_np + amt);
							next_n = PW'(amt);
						end else begin
							tot_n  = sat(tot + amt);
							next_n = PW'(np + amt);
							ofs    = where;
						end
					end
				end
			end
			rbsa_pkg::REQ_FREE: begin
				if (tot >= amt) begin
					if (linear) begin
						if (np - fp >= amt) begin
							ofs    = fp;
							tot_n  = rbsa_pkg::CNT_W'(tot - amt);
							free_n = PW'(fp + amt);
						end
					end else if (tail_fp < amt) begin
						// wrapped free: the skipped tail goes too
						if (np >= amt) begin
							tot_n  = (rel > tot) ? '0 : rbsa_pkg::CNT_W'(tot - rel);
							free_n = PW'(amt);
						end
					end else begin
						ofs    = fp;
						tot_n  = rbsa_pkg::CNT_W'(tot - amt);
						free_n = (e == bs) ? '0 : PW'(e);
					end
					if (tot_n == '0) begin
						next_n = '0;
						free_n = '0;
					end
					res.freed_bytes = tot_q - tot_n;
					res.ok          = (res.freed_bytes != '0);
					if (!res.ok) begin
						ofs = '0;
					end
				end
			end
			default: ;
		endcase
		res.offset = rbsa_pkg::OFS_W'(ofs & OFS_MASK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			next_q <= '0;
			free_q <= '0;
			tot_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
			next_q <= PW'(tot_q);
			free_q <= PW'(tot_q);
		end else if (adv) begin
			next_q <= next_n;
			free_q <= free_n;
			tot_q  <= tot_n;
		end
	end

	`CHK_ALWAYS(a_free_ok, !(adv && req.req_type == rbsa_pkg::REQ_FREE) || (res.ok == (res.freed_bytes != '0)), "free ok does not match released count")
	`CHK_ALWAYS(a_fail_zero, !adv || res.ok || (res.offset == '0 && res.freed_bytes == '0), "failed request carries nonzero fields")
	`CHK_ALWAYS(a_check_pure, !(adv && req.req_type == rbsa_pkg::REQ_CHECK) || (next_n == next_q && free_n == free_q && tot_n == tot_q), "check request changes state")

endmodule

`default_nettype wire

// ===== rtl/ring_buffer_space_allocator_unit.sv =====
// Channel | Dir | Word                                | Accept
// req     | in  | req_type[1:0], amount[16:0]         | valid & ready
// rsp     | out | ok, offset[15:0], freed_bytes[16:0] | valid & ready
// cfg     | in  | cfg_wdata[16:0] = buffer_size       | cfg_we
//
// One request per cycle sustained while rsp takes results; a word taken from req
// goes through the input register, then the result register, where its result
// is presented. The position/total update is a single pass of compares and
// adds between them. A stalled rsp holds the result register; req keeps taking
// words until the input register is also full.
// arst_n clears size, positions, total and both valid flags.
`default_nettype none
`include "assert_macros.svh"

module ring_buffer_space_allocator_unit #(
	parameter int ADDR_BITS = 16
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cfg_we,
	input wire logic [rbsa_pkg::CNT_W-1:0] cfg_wdata,
	rbsa_if.sink                           req,
	rbsa_if.source                         rsp
);

	logic           v_s1;
	rbsa_pkg::req_t req_s1;
	logic           res_v_s2;
	rbsa_pkg::res_t res_s2;
	rbsa_pkg::res_t res_c;
	logic           adv;

	assign adv       = v_s1 && (!res_v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign rsp.valid = res_v_s2;
	assign rsp.data  = res_s2;

	rbsa_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.adv      (adv),
		.req      (req_s1),
		.res      (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			res_v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				res_v_s2 <= 1'b1;
			end else if (rsp.ready) begin
				res_v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	`CHK_NEXT(a_res_hold, res_v_s2 && !rsp.ready, res_v_s2 && $stable(res_s2), "stalled result changed")
	`CHK_NEXT(a_adv_fill, adv, res_v_s2, "processed word lost before result register")
	`CHK_ALWAYS(a_no_drop, !(v_s1 && !adv) || !req.ready, "input register overwritten while held")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef logic [rbsa_pkg::CNT_W-1:0] cnt_t;

	localparam logic [rbsa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned IDLE_PCT [3] = '{0, 15, 50};

	typedef struct packed {
		logic                       is_cfg;
		logic [rbsa_pkg::REQ_W-1:0] kind;
		cnt_t                       amt;
		logic                       pinned;
		rbsa_pkg::res_t             want;
	} step_t;

	localparam rbsa_pkg::res_t R_NONE = '0;
	localparam rbsa_pkg::res_t R_OK   = '{1'b1, 16'd0, 17'd0};

	// directed script; cfg rows write buffer_size from amt
	localparam step_t SCRIPT [30] = '{
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd0,     1'b1, R_OK},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd1,     1'b1, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd0,     1'b1, R_NONE},
		'{1'b0, REQ_UNUSED,          rbsa_pkg::CNT_MAX, 1'b1, R_NONE},
		'{1'b1, rbsa_pkg::REQ_CHECK, 17'd65536, 1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd65536, 1'b1, R_OK},
		'{1'b0, rbsa_pkg::REQ_CHECK, rbsa_pkg::CNT_MAX, 1'b1, R_NONE},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd65536, 1'b1, R_OK},
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd1,     1'b1, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd65537, 1'b1, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd65536, 1'b1, '{1'b1, 16'd0, 17'd65536}},
		'{1'b1, rbsa_pkg::REQ_CHECK, 17'd100,   1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd60,    1'b1, R_OK},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd30,    1'b1, '{1'b1, 16'd60, 17'd0}},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd50,    1'b1, '{1'b1, 16'd0, 17'd50}},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd40,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd20,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd40,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd30,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd60,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd30,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd0,     1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd80,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd10,    1'b0, R_NONE},
		'{1'b1, rbsa_pkg::REQ_CHECK, 17'd60,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_CHECK, 17'd0,     1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd20,    1'b0, R_NONE},
		'{1'b1, rbsa_pkg::REQ_CHECK, 17'd100,   1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_FREE,  17'd50,    1'b0, R_NONE},
		'{1'b0, rbsa_pkg::REQ_ALLOC, 17'd0,     1'b0, R_NONE}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cnt_t cfg_wdata;

	rbsa_if #(.payload_t(rbsa_pkg::req_t)) req_ch ();
	rbsa_if #(.payload_t(rbsa_pkg::res_t)) rsp_ch ();

	ring_buffer_space_allocator_unit #(.ADDR_BITS(16)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// allocator state as the bench sees it
	cnt_t ring_size   = '0;
	cnt_t alloc_pos   = '0;
	cnt_t release_pos = '0;
	cnt_t held_bytes  = '0;
	cnt_t held_blocks [$];

	rbsa_pkg::res_t outcome_q [$];
	logic           pin_en;
	rbsa_pkg::res_t pin_res;
	int unsigned    bad_words = 0;
	int unsigned    send_pct  = 0;
	int unsigned    stall_pct = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int unsigned tail_room(cnt_t pos);
		return (ring_size > pos) ? 32'(ring_size - pos) : 0;
	endfunction

	function automatic cnt_t clip_total(int unsigned v);
		return (v > rbsa_pkg::CNT_MAX) ? rbsa_pkg::CNT_MAX : v[rbsa_pkg::CNT_W-1:0];
	endfunction

	function automatic rbsa_pkg::res_t reserve_or_release(rbsa_pkg::req_t w);
		int unsigned    amt, spot, rel, stop, prior;
		bit             fit, wrap, linear;
		rbsa_pkg::res_t r;
		amt = 32'(w.amount);
		r = '0;
		fit = 0;
		wrap = 0;
		spot = 0;
		unique case (w.req_type)
		rbsa_pkg::REQ_CHECK, rbsa_pkg::REQ_ALLOC: begin
			// a perfectly full ring refuses every check and alloc
			if (!((alloc_pos == release_pos && held_bytes != 0) || amt > ring_size)) begin
				if (alloc_pos >= release_pos) begin
					if (tail_room(alloc_pos) >= amt) begin
						fit = 1;
						spot = 32'(alloc_pos);
					end else if (release_pos >= amt) begin
						fit = 1;
						wrap = 1;
					end
				end else if (release_pos - alloc_pos >= amt) begin
					fit = 1;
					spot = 32'(alloc_pos);
				end
			end
			r.ok = fit;
			if (fit && w.req_type == rbsa_pkg::REQ_ALLOC) begin
				if (wrap) begin
					// skipped tail is booked as held
					held_bytes = clip_total(held_bytes + tail_room(alloc_pos) + amt);
					alloc_pos = w.amount;
				end else begin
					held_bytes = clip_total(held_bytes + amt);
					stop = alloc_pos + amt;
					alloc_pos = stop[rbsa_pkg::CNT_W-1:0];
					r.offset = spot[rbsa_pkg::OFS_W-1:0];
				end
				held_blocks.push_back(w.amount);
			end
		end
		rbsa_pkg::REQ_FREE: begin
			if (held_bytes >= amt) begin
				prior = 32'(held_bytes);
				linear = (release_pos < alloc_pos) ||
					(release_pos == alloc_pos && held_bytes == 0);
				if (linear) begin
					if (alloc_pos - release_pos >= amt) begin
						spot = 32'(release_pos);
						held_bytes = cnt_t'(held_bytes - amt);
						stop = release_pos + amt;
						release_pos = stop[rbsa_pkg::CNT_W-1:0];
					end
				end else if (tail_room(release_pos) < amt) begin
					if (alloc_pos >= amt) begin
						rel = tail_room(release_pos) + amt;
						held_bytes = (rel > held_bytes) ? '0 : cnt_t'(held_bytes - rel);
						release_pos = w.amount;
						spot = 0;
					end
				end else begin
					stop = release_pos + amt;
					spot = 32'(release_pos);
					held_bytes = cnt_t'(held_bytes - amt);
					release_pos = (stop == ring_size) ? '0 : stop[rbsa_pkg::CNT_W-1:0];
				end
				if (held_bytes == 0) begin
					alloc_pos = '0;
					release_pos = '0;
					held_blocks.delete();
				end
				r.freed_bytes = cnt_t'(prior - held_bytes);
				r.ok = (r.freed_bytes != 0);
				if (r.ok)
					r.offset = spot[rbsa_pkg::OFS_W-1:0];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cnt_t pick_amount();
		int unsigned top;
		top = (ring_size > 3) ? 32'(ring_size / 3) : 1;
		case ($urandom_range(0, 19))
		0: return '0;
		1: return ring_size;
		2: return cnt_t'(ring_size + 1);
		3: return rbsa_pkg::CNT_MAX;
		4: return cnt_t'($urandom);
		default: return cnt_t'($urandom_range(1, top));
		endcase
	endfunction

	// mostly alloc / free-oldest traffic so the ring wraps and fills
	function automatic rbsa_pkg::req_t pick_word();
		int unsigned    r;
		rbsa_pkg::req_t w;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			w.req_type = rbsa_pkg::REQ_ALLOC;
			w.amount = pick_amount();
		end else if (r < 70) begin
			w.req_type = rbsa_pkg::REQ_FREE;
			if (held_blocks.size() != 0 && $urandom_range(0, 4) != 0)
				w.amount = held_blocks.pop_front();
			else
				w.amount = cnt_t'($urandom_range(0, held_bytes + 1));
		end else if (r < 85) begin
			w.req_type = rbsa_pkg::REQ_CHECK;
			w.amount = pick_amount();
		end else if (r < 96) begin
			w.req_type = 2'($urandom_range(0, 2));
			w.amount = cnt_t'($urandom);
		end else begin
			w.req_type = REQ_UNUSED;
			w.amount = cnt_t'($urandom);
		end
		return w;
	endfunction

	// returns at the edge where the word is taken; the next word is chosen
	// only at the following falling edge, once the prediction is booked
	task automatic send_word(bit draw, rbsa_pkg::req_t w, bit pinned, rbsa_pkg::res_t want);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_pct) begin
			req_ch.valid <= 1'b0;
			repeat (gap_cycles()) @(negedge clk);
		end
		if (draw)
			w = pick_word();
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		pin_en <= pinned;
		pin_res <= want;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_size(cnt_t v);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		ring_size = v;
		alloc_pos = held_bytes;
		release_pos = held_bytes;
		held_blocks.delete();
	endtask

	initial begin
		int unsigned hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				hold = gap_cycles() - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// result check first, then book the word taken at this edge
	always @(posedge clk) begin
		rbsa_pkg::res_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcome_q.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: unexpected result ok=%0d offset=%0d freed=%0d", $realtime,
							rsp_ch.data.ok, rsp_ch.data.offset, rsp_ch.data.freed_bytes);
				end else begin
					want = outcome_q.pop_front();
					if (rsp_ch.data.ok !== want.ok || rsp_ch.data.offset !== want.offset ||
							rsp_ch.data.freed_bytes !== want.freed_bytes) begin
						bad_words++;
						if (bad_words <= 10)
							$display("%0t: want ok=%0d offset=%0d freed=%0d, got ok=%0d offset=%0d freed=%0d",
								$realtime, want.ok, want.offset, want.freed_bytes, rsp_ch.data.ok,
								rsp_ch.data.offset, rsp_ch.data.freed_bytes);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				want = reserve_or_release(req_ch.data);
				outcome_q.push_back(pin_en ? pin_res : want);
			end
		end
	end

	initial begin
		rbsa_pkg::req_t w;
		cnt_t           phase_size [10];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		pin_en = 1'b0;
		pin_res = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pct = 15;
		stall_pct = 15;
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].is_cfg) begin
				write_size(SCRIPT[i].amt);
			end else begin
				w.req_type = SCRIPT[i].kind;
				w.amount = SCRIPT[i].amt;
				send_word(1'b0, w, SCRIPT[i].pinned, SCRIPT[i].want);
			end
		end

		phase_size = '{17'd1, 17'd0, 17'd16, 17'd100, cnt_t'($urandom_range(200, 4000)),
			17'd65535, 17'd7, 17'd65536, cnt_t'($urandom_range(1, 65536)), 17'd3};
		foreach (phase_size[p]) begin
			send_pct = IDLE_PCT[p % 3];
			stall_pct = IDLE_PCT[(p + 1) % 3];
			write_size(phase_size[p]);
			repeat (95) send_word(1'b1, '0, 1'b0, '0);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		if (bad_words == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rbsa_pkg.sv
rtl/rbsa_if.sv
rtl/rbsa_core.sv
rtl/ring_buffer_space_allocator_unit.sv
bench/tb_top.sv
